### rtl/sdt_pkg.sv
package sdt_pkg;

    localparam int TIME_W = 32;
    localparam int RATE_W = 48;
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 64;
    localparam int DVD_W  = 68;
    localparam int STEP_W = 7;

    localparam logic [RATE_W-1:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MIN = 48'h8000_0000_0000;

    // derivative_order codes
    localparam logic ORDER_FIRST  = 1'b0;
    localparam logic ORDER_SECOND = 1'b1;

    // dividend bits walked per mode: numerator plus fraction shift
    localparam logic [STEP_W-1:0] STEPS_FIRST  = 7'd50;
    localparam logic [STEP_W-1:0] STEPS_SECOND = 7'd68;

    typedef struct packed {
        logic signed [TIME_W-1:0] sample_time;
        logic signed [TIME_W-1:0] sample_value;
        logic                     curve_start;
    } sample_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] mid_time;
        logic signed [RATE_W-1:0] rate;
        logic                     zero_step;
        logic                     overflow;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              big;
        logic [RATE_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/sample_derivative_transform.sv
// sequence: a word that yields a result passes S_DIFF, S_SQUARE (second derivative
// only, with 18 more divide steps), S_LAUNCH and S_DIVIDE to a registered result_valid;
// a zero step skips the divide and goes from S_DIFF straight to the result
// throughput: one word at a time; the radix-2 divider (one quotient bit per cycle)
// sets the pace, and no new word is taken until the result is taken
// reset: rst_n asynchronous active low, clears history, sample count and order
module sample_derivative_transform
    import sdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // sample channel
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    // result channel
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result,
    // derivative_order register
    input  logic    cfg_wen,
    input  logic    cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQUARE,
        S_LAUNCH,
        S_DIVIDE,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic order_reg;

    // sample history
    logic signed [TIME_W-1:0] older_time_reg;
    logic signed [TIME_W-1:0] older_value_reg;
    logic signed [TIME_W-1:0] newer_time_reg;
    logic signed [TIME_W-1:0] newer_value_reg;
    logic [1:0]               held_reg;

    // operands captured at accept
    logic signed [TIME_W-1:0] op_t_reg;
    logic signed [TIME_W-1:0] op_v_reg;
    logic signed [TIME_W-1:0] op_t0_reg;
    logic signed [TIME_W-1:0] op_y0_reg;
    logic signed [TIME_W-1:0] op_y1_reg;
    logic                     op_mode_reg;

    // prepared divide operands
    logic [NUM_W-1:0]   num_mag_reg;
    logic [TIME_W-1:0]  d_mag_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               res_neg_reg;
    logic               lim_min_reg;

    result_t result_reg;
    logic    result_valid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic       accept;
    logic [1:0] held_eff;
    logic       produce;
    logic [1:0] held_next;

    logic signed [TIME_W:0]   t_x;
    logic signed [TIME_W:0]   t0_x;
    logic signed [TIME_W:0]   d;
    logic signed [TIME_W:0]   d_abs;
    logic signed [TIME_W:0]   t_sum;
    logic signed [NUM_W:0]    v_x;
    logic signed [NUM_W:0]    y0_x;
    logic signed [NUM_W:0]    y1_x;
    logic signed [NUM_W:0]    num;
    logic signed [NUM_W:0]    num_abs;
    logic                     num_neg;
    logic                     d_flip;
    logic [RATE_W-1:0]        zero_rate;

    logic [DEN_W-1:0]  d_square;
    logic [RATE_W-1:0] lim;
    logic              clip;
    logic [RATE_W-1:0] mag;
    logic [RATE_W-1:0] final_rate;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid & ~sample_stall;

    // a start flag empties the history before this word is counted
    always_comb
    begin
        held_eff  = sample.curve_start ? 2'd0 : held_reg;
        produce   = (order_reg == ORDER_SECOND) ? (held_eff == 2'd2) : (held_eff != 2'd0);
        held_next = (held_eff == 2'd2) ? 2'd2 : held_eff + 2'd1;
    end

    // differences, midpoint and signs of the captured operands
    always_comb
    begin
        t_x     = {op_t_reg[TIME_W-1], op_t_reg};
        t0_x    = {op_t0_reg[TIME_W-1], op_t0_reg};
        d       = t_x - t0_x;
        d_abs   = d[TIME_W] ? -d : d;
        t_sum   = t_x + t0_x;
        v_x     = {{3{op_v_reg[TIME_W-1]}}, op_v_reg};
        y0_x    = {{3{op_y0_reg[TIME_W-1]}}, op_y0_reg};
        y1_x    = {{3{op_y1_reg[TIME_W-1]}}, op_y1_reg};
        if (op_mode_reg == ORDER_SECOND)
        begin
            num = v_x - {y1_x[NUM_W-1:0], 1'b0} + y0_x;
        end
        else
        begin
            num = v_x - y0_x;
        end
        num_neg = num[NUM_W];
        num_abs = num_neg ? -num : num;
        // only the first derivative divides by a signed step
        d_flip  = (op_mode_reg == ORDER_FIRST) & d[TIME_W];
        if (num_abs == '0)
        begin
            zero_rate = '0;
        end
        else if (num_neg)
        begin
            zero_rate = RATE_MIN;
        end
        else
        begin
            zero_rate = RATE_MAX;
        end
    end

    assign d_square = d_mag_reg * d_mag_reg;

    // clip the unsigned quotient to the signed range, then apply the sign
    always_comb
    begin
        lim        = lim_min_reg ? RATE_MIN : RATE_MAX;
        clip       = div_rsp.big | (div_rsp.quotient > lim);
        mag        = clip ? lim : div_rsp.quotient;
        final_rate = res_neg_reg ? -mag : mag;
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_LAUNCH);
        div_req.dividend = {num_mag_reg, 34'd0};
        div_req.divisor  = den_reg;
        div_req.steps    = (op_mode_reg == ORDER_SECOND) ? STEPS_SECOND : STEPS_FIRST;
    end

    sdt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            order_reg        <= ORDER_FIRST;
            older_time_reg   <= '0;
            older_value_reg  <= '0;
            newer_time_reg   <= '0;
            newer_value_reg  <= '0;
            held_reg         <= 2'd0;
            op_t_reg         <= '0;
            op_v_reg         <= '0;
            op_t0_reg        <= '0;
            op_y0_reg        <= '0;
            op_y1_reg        <= '0;
            op_mode_reg      <= ORDER_FIRST;
            num_mag_reg      <= '0;
            d_mag_reg        <= '0;
            den_reg          <= '0;
            res_neg_reg      <= 1'b0;
            lim_min_reg      <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                order_reg <= cfg_wdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // operands from the history as it stood before this word
                        op_t_reg    <= sample.sample_time;
                        op_v_reg    <= sample.sample_value;
                        op_t0_reg   <= (order_reg == ORDER_SECOND) ? older_time_reg
                                                                   : newer_time_reg;
                        op_y0_reg   <= (order_reg == ORDER_SECOND) ? older_value_reg
                                                                   : newer_value_reg;
                        op_y1_reg   <= newer_value_reg;
                        op_mode_reg <= order_reg;

                        older_time_reg  <= newer_time_reg;
                        older_value_reg <= newer_value_reg;
                        newer_time_reg  <= sample.sample_time;
                        newer_value_reg <= sample.sample_value;
                        held_reg        <= held_next;

                        if (produce)
                        begin
                            state_reg <= S_DIFF;
                        end
                    end
                end

                S_DIFF:
                begin
                    result_reg.mid_time <= t_sum[TIME_W:1];
                    num_mag_reg         <= num_abs[NUM_W-1:0];
                    d_mag_reg           <= d_abs[TIME_W-1:0];
                    den_reg             <= {32'd0, d_abs[TIME_W-1:0]};
                    res_neg_reg         <= num_neg ^ d_flip;
                    // a negative result may reach -2^47 only with a positive divisor
                    lim_min_reg         <= num_neg & ~d_flip;
                    if (d == '0)
                    begin
                        // zero step: saturate by numerator sign, skip the divide
                        result_reg.rate      <= zero_rate;
                        result_reg.zero_step <= 1'b1;
                        result_reg.overflow  <= 1'b0;
                        result_valid_reg     <= 1'b1;
                        state_reg            <= S_OUT;
                    end
                    else if (op_mode_reg == ORDER_SECOND)
                    begin
                        state_reg <= S_SQUARE;
                    end
                    else
                    begin
                        state_reg <= S_LAUNCH;
                    end
                end

                S_SQUARE:
                begin
                    den_reg   <= d_square;
                    state_reg <= S_LAUNCH;
                end

                S_LAUNCH:
                begin
                    state_reg <= S_DIVIDE;
                end

                S_DIVIDE:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg.rate      <= final_rate;
                        result_reg.zero_step <= 1'b0;
                        result_reg.overflow  <= clip;
                        result_valid_reg     <= 1'b1;
                        state_reg            <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (!result_stall)
                    begin
                        result_valid_reg <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no new word is taken while a result waits
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sample_stall)
        else $error("sample accepted while result pending");

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVIDE))
        else $error("divider done outside divide state");

    // a zero step never reports a clipped quotient
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.zero_step && result.overflow))
        else $error("zero_step and overflow both set");

    // result valid rises only after a finished divide or a zero step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(div_rsp.done) || result.zero_step))
        else $error("result without finished divide");

endmodule

### rtl/sdt_div.sv
module sdt_div
    import sdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [RATE_W-1:0] q_reg;
    logic              big_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W+1:0]  diff;
    logic              qbit;
    logic [DEN_W-1:0]  rem_next;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, den_reg};
        qbit     = ~diff[DEN_W+1];
        rem_next = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            big_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                dvd_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
                big_reg  <= 1'b0;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                rem_reg <= rem_next;
                // sticky: quotient no longer fits the result width
                big_reg <= big_reg | q_reg[RATE_W-1];
                q_reg   <= {q_reg[RATE_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.big      = big_reg;
    assign rsp.quotient = q_reg;

endmodule
